FILE: design/sprs_pkg.sv
// ----------------------------------------------------------------------------
// sprs_pkg - shared types and codes for the switch power and reset sequencer
// sequencer state codes, pin action codes, request kinds and register indexes
// ----------------------------------------------------------------------------
package sprs_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;

  // request kinds
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_OFF   = 2'd2;

  // sequencer states
  localparam logic [2:0] ST_OFF   = 3'd0;
  localparam logic [2:0] ST_WSUP  = 3'd1;
  localparam logic [2:0] ST_WON   = 3'd2;
  localparam logic [2:0] ST_ON    = 3'd3;
  localparam logic [2:0] ST_RASRT = 3'd4;
  localparam logic [2:0] ST_RREL  = 3'd5;

  // pin actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_PWRON   = 3'd1;
  localparam logic [2:0] ACT_SPI     = 3'd2;
  localparam logic [2:0] ACT_ASSERT  = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;
  localparam logic [2:0] ACT_RESUME  = 3'd5;
  localparam logic [2:0] ACT_PWROFF  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_POWER_ON_TICKS      = 2'd0;
  localparam logic [1:0] REG_RESET_ASSERT_TICKS  = 2'd1;
  localparam logic [1:0] REG_RESET_RELEASE_TICKS = 2'd2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_WIDTH-1:0]   limit_t;

endpackage

FILE: design/switch_power_reset_sequencer.sv
// ----------------------------------------------------------------------------
// switch_power_reset_sequencer - power-up and reset sequencing for a switch chip
// steps through off, wait-supply, wait-on, on, reset-assert and reset-release on
// tick, reset and force-off requests, with tick-counted timed waits
// ----------------------------------------------------------------------------
// an accepted request passes through the input register, then the result register
// throughput: one request per clock while out_stall is low; the whole state update
//   sits between the input register and the result register
// a full result register only holds up the input side while out_stall is high
// reset: rst (synchronous, active high) puts the sequencer in off, clears all
//   counters and the pending flag, and loads the limits 10, 2 and 10
module switch_power_reset_sequencer
  import sprs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic                 power_cond,
  input  logic                 supply_ok,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           seq_state,
  output logic [2:0]           action,
  output logic                 power_good,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  // compare width that holds both a counter and a limit
  localparam int CmpW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam count_t CntMax = '1;

  // configuration registers
  limit_t power_on_ticks;
  limit_t reset_assert_ticks;
  limit_t reset_release_ticks;

  // sequencer state
  logic [2:0] ctrl_state,     ctrl_state_next;
  count_t     power_on_count, power_on_count_next;
  count_t     assert_count,   assert_count_next;
  count_t     release_count,  release_count_next;
  logic       reset_pending,  reset_pending_next;
  logic [2:0] action_next;

  // input register
  logic       req_valid;
  logic [1:0] req_kind;
  logic       req_pc;
  logic       req_sup;

  logic advance;
  logic process;

  // the result register moves on when empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign process  = req_valid && advance;
  assign in_stall = req_valid && !advance;
  assign cfg_ready = 1'b1;

  // ---- configuration writes -------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      power_on_ticks      <= CFG_WIDTH'(10);
      reset_assert_ticks  <= CFG_WIDTH'(2);
      reset_release_ticks <= CFG_WIDTH'(10);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POWER_ON_TICKS:      power_on_ticks      <= cfg_data;
        REG_RESET_ASSERT_TICKS:  reset_assert_ticks  <= cfg_data;
        REG_RESET_RELEASE_TICKS: reset_release_ticks <= cfg_data;
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // ---- input register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_kind <= req_type;
      req_pc   <= power_cond;
      req_sup  <= supply_ok;
    end
  end

  // ---- next-state logic -----------------------------------------------------
  // saturating increments of the three counters
  count_t pon_inc, asrt_inc, rel_inc;
  logic   pon_done, asrt_done, rel_done;

  assign pon_inc  = (power_on_count == CntMax) ? CntMax : power_on_count + 1'b1;
  assign asrt_inc = (assert_count   == CntMax) ? CntMax : assert_count + 1'b1;
  assign rel_inc  = (release_count  == CntMax) ? CntMax : release_count + 1'b1;

  // limit checks use the incremented value
  assign pon_done  = CmpW'(pon_inc)  >= CmpW'(power_on_ticks);
  assign asrt_done = CmpW'(asrt_inc) >= CmpW'(reset_assert_ticks);
  assign rel_done  = CmpW'(rel_inc)  >= CmpW'(reset_release_ticks);

  logic power_down;

  always_comb begin
    ctrl_state_next     = ctrl_state;
    power_on_count_next = power_on_count;
    assert_count_next   = assert_count;
    release_count_next  = release_count;
    reset_pending_next  = reset_pending;
    action_next         = ACT_NONE;
    power_down          = 1'b0;

    case (req_kind)
      REQ_TICK: begin
        unique case (ctrl_state)
          ST_WSUP: begin
            if (!req_pc) begin
              power_down = 1'b1;
            end else if (req_sup) begin
              ctrl_state_next = ST_WON;
            end
          end
          ST_WON: begin
            if (!req_pc || !req_sup) begin
              power_down = 1'b1;
            end else begin
              power_on_count_next = pon_inc;
              if (pon_done) begin
                ctrl_state_next = ST_ON;
                action_next     = ACT_SPI;
              end
            end
          end
          ST_ON: begin
            if (!req_pc || !req_sup) begin
              power_down = 1'b1;
            end else if (reset_pending) begin
              reset_pending_next = 1'b0;
              ctrl_state_next    = ST_RASRT;
              action_next        = ACT_ASSERT;
            end
          end
          ST_RASRT: begin
            if (!req_pc || !req_sup) begin
              power_down = 1'b1;
            end else begin
              assert_count_next = asrt_inc;
              if (asrt_done) begin
                ctrl_state_next = ST_RREL;
                action_next     = ACT_RELEASE;
              end
            end
          end
          ST_RREL: begin
            if (!req_pc || !req_sup) begin
              power_down = 1'b1;
            end else begin
              release_count_next = rel_inc;
              if (rel_done) begin
                assert_count_next  = '0;
                release_count_next = '0;
                ctrl_state_next    = ST_ON;
                action_next        = ACT_RESUME;
              end
            end
          end
          default: begin
            // off, and any unreachable code, which behaves as off
            if (req_pc) begin
              ctrl_state_next = ST_WSUP;
              action_next     = ACT_PWRON;
            end else begin
              ctrl_state_next = ST_OFF;
            end
          end
        endcase
      end
      REQ_RESET: begin
        reset_pending_next = 1'b1;
      end
      REQ_OFF: begin
        if (ctrl_state != ST_OFF && ctrl_state <= ST_RREL) begin
          power_down = 1'b1;
        end
      end
      default: ;  // unused request kind is ignored
    endcase

    if (power_down) begin
      power_on_count_next = '0;
      assert_count_next   = '0;
      release_count_next  = '0;
      reset_pending_next  = 1'b0;
      ctrl_state_next     = ST_OFF;
      action_next         = ACT_PWROFF;
    end

    if (ctrl_state_next > ST_RREL) begin
      ctrl_state_next = ST_OFF;
    end
  end

  // ---- state registers ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state     <= ST_OFF;
      power_on_count <= '0;
      assert_count   <= '0;
      release_count  <= '0;
      reset_pending  <= 1'b0;
    end else if (process) begin
      ctrl_state     <= ctrl_state_next;
      power_on_count <= power_on_count_next;
      assert_count   <= assert_count_next;
      release_count  <= release_count_next;
      reset_pending  <= reset_pending_next;
    end
  end

  // ---- result register ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      seq_state  <= ctrl_state_next;
      action     <= action_next;
      power_good <= (ctrl_state_next == ST_ON) && !reset_pending_next;
    end
  end

  // ---- checks -----------------------------------------------------------------
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    ctrl_state <= ST_RREL)
    else $error("sequencer state left the legal range");

  a_assert_count_scope: assert property (@(posedge clk) disable iff (rst)
    (assert_count != '0) |-> (ctrl_state == ST_RASRT || ctrl_state == ST_RREL))
    else $error("reset assert counter live outside the reset states");

  a_pwroff_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_PWROFF) |-> (seq_state == ST_OFF && !power_good))
    else $error("power off result not in off state");

  a_spi_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == ACT_SPI || action == ACT_RESUME)) |-> seq_state == ST_ON)
    else $error("spi mode or resume result not in on state");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && req_valid))
    else $error("request side stalled without a blocked result");

endmodule
